/* sv/max_flow_engine_defines.svh */
// Assertion macros for the max flow engine.
// Used by the top level only; expects aclk and aresetn in scope.
`ifndef MAX_FLOW_ENGINE_DEFINES_SVH
`define MAX_FLOW_ENGINE_DEFINES_SVH

// same-cycle implication
`define MFE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("max_flow_engine check failed");

// next-cycle implication
`define MFE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("max_flow_engine check failed");

`endif

/* sv/mfe_pkg.sv */
// Shared types and constants of the max flow engine.
// No dependencies; used by the top level, mfe_alu and the testbench.
`timescale 1ns / 1ps

package mfe_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int CAP_BITS_DEF  = 16;
    localparam int FLOW_W        = 22;
    localparam int CFG_W         = 7;
    localparam int IDX_W         = 2;

    localparam logic [IDX_W-1:0] REG_NODE_COUNT = 2'd0;
    localparam logic [IDX_W-1:0] REG_SOURCE     = 2'd1;
    localparam logic [IDX_W-1:0] REG_SINK       = 2'd2;

    localparam logic [1:0] ALU_MIN = 2'd0;
    localparam logic [1:0] ALU_SUB = 2'd1;
    localparam logic [1:0] ALU_ADD = 2'd2;

    typedef struct packed {
        logic [5:0]  from_node;
        logic [5:0]  to_node;
        logic [15:0] edge_capacity;
        logic        last_edge;
    } in_word_t;

    typedef struct packed {
        logic [FLOW_W-1:0] total_flow;
        logic              edge_dropped;
    } out_word_t;

endpackage

/* sv/max_flow_engine.sv */
// Top level of the max flow engine: sequencer, residual matrix and BFS state.
// Depends on mfe_pkg, mfe_ram, mfe_alu and max_flow_engine_defines.svh.
//
// Usage: edges arrive on s_* (valid/ready), one word per cycle while idle.
// Each word writes the residual matrix entry for (from_node, to_node); a word
// naming a node at or beyond the node count is dropped and flagged. The word
// with last_edge set starts Edmonds-Karp from source_node to sink_node.
// A BFS round passes S_SCAN, S_EVAL per scanned matrix entry and S_DEQ, S_DEQW
// per dequeued node; an augmentation passes S_AUG, S_AUGP, S_AUGR1, S_AUGR2 per
// path edge. All matrix traffic goes through one RAM port pair and one shared
// min/sub/add unit. The result word (total_flow, edge_dropped) is held in an
// output register on m_*; then every matrix entry is cleared with s_ready low.
// A stalled receiver only blocks the next result, not the clearing pass, which
// also runs after reset before the first edge is taken. Configuration is to be
// written through cfg_* while idle (unenforced by the block), effective at once.
`timescale 1ns / 1ps
`include "max_flow_engine_defines.svh"

module max_flow_engine #(
    parameter int MAX_NODES = mfe_pkg::MAX_NODES_DEF,
    parameter int CAP_BITS  = mfe_pkg::CAP_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [mfe_pkg::IDX_W-1:0]  cfg_index,
    input  logic [mfe_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  mfe_pkg::in_word_t          s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output mfe_pkg::out_word_t         m_data
);

    localparam int NW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int KW = (CW > 7) ? CW : 7;
    localparam int RW = CAP_BITS + 1;
    localparam int QW = NW + RW;
    localparam logic [15:0] CAP_MASK =
        (CAP_BITS >= 16) ? 16'hFFFF : 16'((64'd1 << CAP_BITS) - 64'd1);
    localparam logic [RW-1:0] RES_LIMIT = '1;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_INIT  = 4'd3;
    localparam logic [3:0] S_DEQ   = 4'd4;
    localparam logic [3:0] S_DEQW  = 4'd5;
    localparam logic [3:0] S_SCAN  = 4'd6;
    localparam logic [3:0] S_EVAL  = 4'd7;
    localparam logic [3:0] S_AUG   = 4'd8;
    localparam logic [3:0] S_AUGP  = 4'd9;
    localparam logic [3:0] S_AUGR1 = 4'd10;
    localparam logic [3:0] S_AUGR2 = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0]                state_reg, state_next;
    logic [2*NW-1:0]           clr_reg, clr_next;
    logic [6:0]                ncount_reg;
    logic [5:0]                src_cfg_reg, dst_cfg_reg;
    logic                      drop_reg, drop_next;
    logic [mfe_pkg::FLOW_W-1:0] flow_reg, flow_next;
    logic [CW-1:0]             head_reg, head_next, tail_reg, tail_next, v_reg, v_next;
    logic [NW-1:0]             u_reg, u_next, cur_reg, cur_next, prev_reg, prev_next;
    logic [RW-1:0]             bu_reg, bu_next, bott_reg, bott_next;
    logic [MAX_NODES-1:0]      visited_reg, visited_next;
    logic                      m_valid_reg;
    mfe_pkg::out_word_t        m_data_reg;

    logic [KW-1:0] n_k, from_k, to_k, src_k, dst_k, max_k;
    logic [CW-1:0] n_c;
    logic [NW-1:0] src_n, dst_n, v_n;
    logic          in_range, accept, cfg_bad;

    logic          mw_en;
    logic [2*NW-1:0] mw_addr, mr_addr;
    logic [RW-1:0] mw_data, m_rdata;
    logic          qw_en;
    logic [NW-1:0] qw_addr;
    logic [QW-1:0] qw_data, q_rdata;
    logic          pw_en;
    logic [NW-1:0] p_rdata;
    logic [1:0]    alu_op;
    logic [RW-1:0] alu_a, alu_b, alu_y;

    assign max_k    = KW'(MAX_NODES);
    assign n_k      = (KW'(ncount_reg) < max_k) ? KW'(ncount_reg) : max_k;
    assign n_c      = CW'(n_k);
    assign from_k   = KW'(s_data.from_node);
    assign to_k     = KW'(s_data.to_node);
    assign src_k    = KW'(src_cfg_reg);
    assign dst_k    = KW'(dst_cfg_reg);
    assign src_n    = NW'(src_k);
    assign dst_n    = NW'(dst_k);
    assign v_n      = NW'(v_reg);
    assign in_range = (from_k < n_k) && (to_k < n_k);
    assign cfg_bad  = (src_k >= n_k) || (dst_k >= n_k) || (src_k == dst_k);
    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    mfe_ram #(.W(RW), .AW(2*NW)) u_matrix (
        .aclk(aclk), .we(mw_en), .waddr(mw_addr), .wdata(mw_data),
        .raddr(mr_addr), .rdata(m_rdata)
    );

    mfe_ram #(.W(QW), .AW(NW)) u_queue (
        .aclk(aclk), .we(qw_en), .waddr(qw_addr), .wdata(qw_data),
        .raddr(NW'(head_reg)), .rdata(q_rdata)
    );

    mfe_ram #(.W(NW), .AW(NW)) u_parent (
        .aclk(aclk), .we(pw_en), .waddr(v_n), .wdata(u_reg),
        .raddr(cur_reg), .rdata(p_rdata)
    );

    mfe_alu #(.W(RW)) u_alu (.op(alu_op), .a(alu_a), .b(alu_b), .y(alu_y));

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ncount_reg  <= 7'd64;
            src_cfg_reg <= 6'd0;
            dst_cfg_reg <= 6'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mfe_pkg::REG_NODE_COUNT: ncount_reg  <= cfg_wdata;
                mfe_pkg::REG_SOURCE:     src_cfg_reg <= cfg_wdata[5:0];
                mfe_pkg::REG_SINK:       dst_cfg_reg <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        drop_next    = drop_reg;
        flow_next    = flow_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        v_next       = v_reg;
        u_next       = u_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        bu_next      = bu_reg;
        bott_next    = bott_reg;
        visited_next = visited_reg;
        mw_en        = 1'b0;
        mw_addr      = clr_reg;
        mw_data      = '0;
        mr_addr      = {u_reg, v_n};
        qw_en        = 1'b0;
        qw_addr      = NW'(tail_reg);
        qw_data      = {v_n, alu_y};
        pw_en        = 1'b0;
        alu_op       = mfe_pkg::ALU_MIN;
        alu_a        = bu_reg;
        alu_b        = m_rdata;

        case (state_reg)
            S_CLEAR: begin
                mw_en    = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                mw_addr = {NW'(from_k), NW'(to_k)};
                mw_data = RW'(s_data.edge_capacity & CAP_MASK);
                if (accept) begin
                    mw_en = in_range;
                    if (!in_range) begin
                        drop_next = 1'b1;
                    end
                    if (s_data.last_edge) begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                flow_next  = '0;
                state_next = cfg_bad ? S_OUT : S_INIT;
            end
            S_INIT: begin
                visited_next        = '0;
                visited_next[src_n] = 1'b1;
                qw_en      = 1'b1;
                qw_addr    = '0;
                qw_data    = {src_n, RES_LIMIT};
                head_next  = '0;
                tail_next  = CW'(1);
                state_next = S_DEQ;
            end
            S_DEQ: begin
                // queue empty: no augmenting path left
                state_next = (head_reg == tail_reg) ? S_OUT : S_DEQW;
            end
            S_DEQW: begin
                u_next     = q_rdata[QW-1:RW];
                bu_next    = q_rdata[RW-1:0];
                head_next  = head_reg + 1'b1;
                v_next     = '0;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                state_next = S_EVAL;
            end
            S_EVAL: begin
                v_next     = v_reg + 1'b1;
                state_next = (v_reg + 1'b1 == n_c) ? S_DEQ : S_SCAN;
                if (!visited_reg[v_n] && (m_rdata != '0)) begin
                    visited_next[v_n] = 1'b1;
                    pw_en             = 1'b1;
                    if (v_n == dst_n) begin
                        bott_next  = alu_y;
                        flow_next  = flow_reg + mfe_pkg::FLOW_W'(alu_y);
                        cur_next   = dst_n;
                        state_next = S_AUG;
                    end else if (tail_reg < CW'(MAX_NODES)) begin
                        qw_en     = 1'b1;
                        tail_next = tail_reg + 1'b1;
                    end
                end
            end
            S_AUG: begin
                state_next = (cur_reg == src_n) ? S_INIT : S_AUGP;
            end
            S_AUGP: begin
                prev_next  = p_rdata;
                mr_addr    = {p_rdata, cur_reg};
                state_next = S_AUGR1;
            end
            S_AUGR1: begin
                // forward edge loses the bottleneck
                alu_op     = mfe_pkg::ALU_SUB;
                alu_a      = m_rdata;
                alu_b      = bott_reg;
                mw_en      = 1'b1;
                mw_addr    = {prev_reg, cur_reg};
                mw_data    = alu_y;
                mr_addr    = {cur_reg, prev_reg};
                state_next = S_AUGR2;
            end
            S_AUGR2: begin
                alu_op     = mfe_pkg::ALU_ADD;
                alu_a      = m_rdata;
                alu_b      = bott_reg;
                mw_en      = 1'b1;
                mw_addr    = {cur_reg, prev_reg};
                mw_data    = alu_y;
                cur_next   = prev_reg;
                state_next = S_AUG;
            end
            S_OUT: begin
                // hold until the output register is free
                if (!m_valid_reg) begin
                    drop_next  = 1'b0;
                    clr_next   = '0;
                    state_next = S_CLEAR;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            drop_reg    <= 1'b0;
            flow_reg    <= '0;
            visited_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            drop_reg    <= drop_next;
            flow_reg    <= flow_next;
            visited_reg <= visited_next;
            if (state_reg == S_OUT && !m_valid_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
        v_reg    <= v_next;
        u_reg    <= u_next;
        cur_reg  <= cur_next;
        prev_reg <= prev_next;
        bu_reg   <= bu_next;
        bott_reg <= bott_next;
        if (state_reg == S_OUT && !m_valid_reg) begin
            m_data_reg.total_flow   <= flow_reg;
            m_data_reg.edge_dropped <= drop_reg;
        end
    end

    `MFE_ASSERT_IMPL(a_src_visited, state_reg == S_EVAL, visited_reg[src_n])
    `MFE_ASSERT_IMPL(a_queue_order, state_reg == S_DEQ, head_reg <= tail_reg)
    `MFE_ASSERT_NEXT(a_result_loads, state_reg == S_OUT && !m_valid_reg,
        m_valid && state_reg == S_CLEAR)

endmodule

/* sv/mfe_ram.sv */
// Simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mfe_ram #(
    parameter int W  = 17,
    parameter int AW = 12
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [0:(1<<AW)-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/mfe_alu.sv */
// Shared residual unit: minimum, subtract or add on residual-width values.
// Depends on mfe_pkg for the operation codes.
`timescale 1ns / 1ps

module mfe_alu #(
    parameter int W = 17
) (
    input  logic [1:0]   op,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] y
);

    always_comb begin
        case (op)
            mfe_pkg::ALU_MIN: y = (a < b) ? a : b;
            mfe_pkg::ALU_SUB: y = a - b;
            mfe_pkg::ALU_ADD: y = a + b;
            default:          y = a;
        endcase
    end

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for max_flow_engine: loads edge words, predicts flow.
// Depends on mfe_pkg and the max_flow_engine RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int NODES      = 64;
    localparam int CLEAR_WAIT = 4400;
    localparam int MAX_SHOWN  = 10;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_wr_en = 1'b0;
    logic [mfe_pkg::IDX_W-1:0] cfg_index = mfe_pkg::REG_NODE_COUNT;
    logic [mfe_pkg::CFG_W-1:0] cfg_wdata = '0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    mfe_pkg::in_word_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    mfe_pkg::out_word_t m_data;

    max_flow_engine dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #1 aclk = ~aclk;

    // predictor state
    longint    residual[NODES][NODES];
    bit        drop_flag;
    logic [6:0] node_cnt = 7'd64;
    logic [5:0] src_node = 6'd0;
    logic [5:0] snk_node = 6'd1;

    mfe_pkg::in_word_t  edge_q[$];
    mfe_pkg::out_word_t flow_q[$];
    int        mismatches = 0;
    int        accepted = 0;
    bit        idle_on = 1'b1;
    int        send_gap = 0;
    int        recv_gap = 0;

    function automatic int active_nodes();
        return (node_cnt < NODES) ? int'(node_cnt) : NODES;
    endfunction

    // Edmonds-Karp over the predicted residual matrix, scan in index order
    function automatic logic [mfe_pkg::FLOW_W-1:0] solve_flow();
        int     n, u, v, head, tail, cur, prev;
        int     parent[NODES];
        int     bfs_q[NODES];
        longint bottle[NODES];
        bit     seen[NODES];
        longint total, b, c;
        bit     found;
        n = active_nodes();
        total = 0;
        if (src_node >= n || snk_node >= n || src_node == snk_node)
            return '0;
        forever begin
            for (int i = 0; i < NODES; i++) seen[i] = 1'b0;
            head = 0;
            tail = 0;
            found = 1'b0;
            b = 0;
            seen[src_node] = 1'b1;
            parent[src_node] = src_node;
            bottle[src_node] = (longint'(1) << (mfe_pkg::CAP_BITS_DEF + 1)) - 1;
            bfs_q[tail++] = src_node;
            while (head < tail && !found) begin
                u = bfs_q[head++];
                for (v = 0; v < n && !found; v++) begin
                    c = residual[u][v];
                    if (!seen[v] && c > 0) begin
                        seen[v] = 1'b1;
                        parent[v] = u;
                        bottle[v] = (bottle[u] < c) ? bottle[u] : c;
                        if (v == snk_node) begin
                            found = 1'b1;
                            b = bottle[v];
                        end else if (tail < NODES) begin
                            bfs_q[tail++] = v;
                        end
                    end
                end
            end
            if (!found) break;
            total += b;
            cur = snk_node;
            while (cur != src_node) begin
                prev = parent[cur];
                residual[prev][cur] -= b;
                residual[cur][prev] += b;
                cur = prev;
            end
        end
        return total[mfe_pkg::FLOW_W-1:0];
    endfunction

    function automatic void load_edge(mfe_pkg::in_word_t w);
        int n;
        mfe_pkg::out_word_t r;
        n = active_nodes();
        if (w.from_node < n && w.to_node < n)
            residual[w.from_node][w.to_node] = w.edge_capacity;
        else
            drop_flag = 1'b1;
        if (w.last_edge) begin
            r.total_flow = solve_flow();
            r.edge_dropped = drop_flag;
            flow_q = {flow_q, r};
            for (int i = 0; i < NODES; i++)
                for (int j = 0; j < NODES; j++) residual[i][j] = 0;
            drop_flag = 1'b0;
        end
    endfunction

    // edge driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                load_edge(s_data);
                accepted++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (edge_q.size() > 0) begin
                    s_data <= edge_q.pop_front();
                    s_valid <= 1'b1;
                    send_gap <= idle_on ? $urandom_range(0, 3) : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            if (flow_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result word: flow %0d dropped %0b",
                             m_data.total_flow, m_data.edge_dropped);
            end else begin
                mfe_pkg::out_word_t want;
                want = flow_q.pop_front();
                if (m_data.total_flow !== want.total_flow ||
                    m_data.edge_dropped !== want.edge_dropped) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("result mismatch: flow exp %0d got %0d, dropped exp %0b got %0b",
                                 want.total_flow, m_data.total_flow,
                                 want.edge_dropped, m_data.edge_dropped);
                end
            end
            recv_gap <= idle_on ? $urandom_range(0, 3) : 0;
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic write_reg(logic [mfe_pkg::IDX_W-1:0] idx, int value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[mfe_pkg::CFG_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            mfe_pkg::REG_NODE_COUNT: node_cnt = value[6:0];
            mfe_pkg::REG_SOURCE:     src_node = value[5:0];
            mfe_pkg::REG_SINK:       snk_node = value[5:0];
            default: ;
        endcase
    endtask

    task automatic setup(int cnt, int src, int snk);
        write_reg(mfe_pkg::REG_NODE_COUNT, cnt);
        write_reg(mfe_pkg::REG_SOURCE, src);
        write_reg(mfe_pkg::REG_SINK, snk);
    endtask

    task automatic push_edge(int f, int t, int cap, bit last);
        mfe_pkg::in_word_t w;
        w.from_node = f[5:0];
        w.to_node = t[5:0];
        w.edge_capacity = cap[15:0];
        w.last_edge = last;
        edge_q = {edge_q, w};
    endtask

    // hold until every word is taken and every result seen, then let clearing end
    task automatic drain();
        do @(posedge aclk);
        while (edge_q.size() > 0 || s_valid || flow_q.size() > 0);
        repeat (CLEAR_WAIT) @(posedge aclk);
    endtask

    function automatic int pick_node(int n);
        if ($urandom_range(0, 15) == 0) return $urandom_range(0, 63);
        return (n > 0) ? $urandom_range(0, n - 1) : 0;
    endfunction

    task automatic random_graph(int edges);
        int n, f, t, cap;
        n = active_nodes();
        for (int k = 0; k < edges; k++) begin
            f = pick_node(n);
            t = pick_node(n);
            case ($urandom_range(0, 5))
                0, 1: f = src_node;
                2, 3: t = snk_node;
                default: ;
            endcase
            case ($urandom_range(0, 3))
                0: cap = $urandom_range(0, 65535);
                1: cap = ($urandom_range(0, 1) == 1) ? 65535 : 0;
                default: cap = $urandom_range(1, 40);
            endcase
            push_edge(f, t, cap, k == edges - 1);
        end
    endtask

    initial begin
        int cnt, src, snk;
        for (int i = 0; i < NODES; i++)
            for (int j = 0; j < NODES; j++) residual[i][j] = 0;
        drop_flag = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (CLEAR_WAIT) @(posedge aclk);

        // reset defaults, widest capacity
        push_edge(0, 1, 65535, 1'b1);
        drain();
        // small diamond with cross edge, self loop, overwrite and a dropped edge
        setup(4, 0, 3);
        push_edge(0, 1, 5, 1'b0);
        push_edge(0, 2, 7, 1'b0);
        push_edge(1, 3, 4, 1'b0);
        push_edge(2, 3, 9, 1'b0);
        push_edge(1, 2, 3, 1'b0);
        push_edge(2, 2, 9, 1'b0);
        push_edge(0, 1, 8, 1'b0);
        push_edge(5, 1, 6, 1'b0);
        push_edge(3, 0, 0, 1'b1);
        drain();
        // source equals sink
        setup(4, 2, 2);
        push_edge(2, 3, 10, 1'b0);
        push_edge(3, 2, 10, 1'b1);
        drain();
        // zero node count drops everything
        setup(0, 0, 1);
        push_edge(0, 1, 100, 1'b1);
        drain();
        // count above the node limit, top node as source
        setup(127, 63, 0);
        push_edge(63, 0, 1, 1'b0);
        push_edge(63, 63, 65535, 1'b1);
        drain();
        // source out of range
        setup(3, 5, 1);
        push_edge(0, 1, 20, 1'b1);
        drain();
        // lower the count in the middle of a load
        setup(8, 0, 1);
        push_edge(0, 6, 10, 1'b0);
        push_edge(6, 1, 10, 1'b0);
        drain();
        write_reg(mfe_pkg::REG_NODE_COUNT, 4);
        push_edge(0, 1, 2, 1'b1);
        drain();

        while (accepted < 1100) begin
            idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0: cnt = 64;
                1: cnt = $urandom_range(0, 127);
                2: cnt = 1;
                default: cnt = $urandom_range(2, 12);
            endcase
            if (cnt >= 2 && $urandom_range(0, 9) != 0) begin
                src = $urandom_range(0, (cnt < 64 ? cnt : 64) - 1);
                snk = $urandom_range(0, (cnt < 64 ? cnt : 64) - 1);
            end else begin
                src = $urandom_range(0, 63);
                snk = $urandom_range(0, 63);
            end
            setup(cnt, src, snk);
            repeat ($urandom_range(1, 3))
                random_graph((cnt >= 32) ? $urandom_range(2, 10) : $urandom_range(3, 16));
            drain();
        end

        if (mismatches == 0 && flow_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
